/* hdl/bmprle_pkg.sv */
// ----------------------------------------------------------------------------
// bmprle_pkg
// Shared types and constants of the palette bitmap pixel-data decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bmprle_pkg;

   localparam int unsigned MAX_DIMENSION = 4096;
   localparam int unsigned DIM_W         = $clog2(MAX_DIMENSION) + 1;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_DEPTH      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RUN_LENGTH_CODED = 2'd3;

   // result kinds
   localparam logic KIND_RUN       = 1'b0;
   localparam logic KIND_IMAGE_END = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       image_start;
   } req_item_type;

   typedef struct packed {
      logic        result_kind;
      logic [11:0] run_x;
      logic [11:0] run_y;
      logic [7:0]  run_length;
      logic [7:0]  first_index;
      logic [7:0]  second_index;
   } rsp_item_type;

   typedef struct packed {
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic        pixel_depth;
      logic        run_length_coded;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      image_width:      13'd1,
      image_height:     13'd1,
      pixel_depth:      1'b1,
      run_length_coded: 1'b0
   };

   // limit a dimension register to 1..MAX_DIMENSION
   function automatic logic [12:0] clamp_dim(input logic [12:0] v);
      if (v == 13'd0) begin
         return 13'd1;
      end
      if (v > 13'(MAX_DIMENSION)) begin
         return 13'(MAX_DIMENSION);
      end
      return v;
   endfunction

endpackage

`default_nettype wire

/* hdl/bmprle_decode.sv */
// ----------------------------------------------------------------------------
// bmprle_decode
// Parse state of the pixel-data stream and the one-byte step that updates it
// and forms at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module bmprle_decode (
   input  wire                        clock,
   input  wire                        reset,
   input  bmprle_pkg::cfg_type        cfg,
   input  wire                        step,
   input  bmprle_pkg::req_item_type   item,
   output logic                       res_valid,
   output bmprle_pkg::rsp_item_type   res_item
);
   import bmprle_pkg::*;

   localparam logic [2:0] PH_COUNT    = 3'd0;
   localparam logic [2:0] PH_VALUE    = 3'd1;
   localparam logic [2:0] PH_ESCAPE   = 3'd2;
   localparam logic [2:0] PH_DELTA_X  = 3'd3;
   localparam logic [2:0] PH_DELTA_Y  = 3'd4;
   localparam logic [2:0] PH_ABS_DATA = 3'd5;
   localparam logic [2:0] PH_ABS_PAD  = 3'd6;

   logic [2:0]         phase_ff, phase_in;
   logic [15:0]        col_ff, col_in;
   logic signed [13:0] row_ff, row_in;
   logic [7:0]         pend_ff, pend_in;
   logic [7:0]         abs_left_ff, abs_left_in;
   logic               pad_ff, pad_in;
   logic [11:0]        rbc_ff, rbc_in;
   logic [7:0]         dx_ff, dx_in;
   logic               done_ff, done_in;

   // state as seen by this byte, after a possible image restart
   logic [2:0]         e_phase;
   logic [15:0]        e_col;
   logic signed [13:0] e_row;
   logic [7:0]         e_pend;
   logic [7:0]         e_abs_left;
   logic               e_pad;
   logic [11:0]        e_rbc;
   logic [7:0]         e_dx;
   logic               e_done;

   logic [12:0] w_cl;
   logic [12:0] h_cl;
   logic [13:0] row_bytes;
   logic [12:0] rbc_inc;
   logic [7:0]  c;
   logic        eight;

   logic        emit_req;
   logic [7:0]  emit_len;
   logic [7:0]  emit_a;
   logic [7:0]  emit_b;
   logic        end_res;
   logic [7:0]  abs_len;

   logic        in_image;
   logic [12:0] room;
   logic [7:0]  clip_len;
   logic        emit_ok;

   function automatic logic [15:0] col_add(input logic [15:0] col, input logic [7:0] amt);
      logic [16:0] s;
      s = {1'b0, col} + {9'd0, amt};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   function automatic logic signed [13:0] row_sub(input logic signed [13:0] row,
                                                  input logic [7:0] n);
      logic signed [13:0] d;
      d = row - $signed({6'd0, n});
      if (d < -14'sd1) begin
         d = -14'sd1;
      end
      return d;
   endfunction

   assign w_cl  = clamp_dim(cfg.image_width);
   assign h_cl  = clamp_dim(cfg.image_height);
   assign c     = item.data_byte;
   assign eight = cfg.pixel_depth;

   always_comb begin
      if (item.image_start) begin
         e_phase    = PH_COUNT;
         e_col      = 16'd0;
         e_row      = $signed({1'b0, h_cl} - 14'd1);
         e_pend     = 8'd0;
         e_abs_left = 8'd0;
         e_pad      = 1'b0;
         e_rbc      = 12'd0;
         e_dx       = 8'd0;
         e_done     = 1'b0;
      end else begin
         e_phase    = phase_ff;
         e_col      = col_ff;
         e_row      = row_ff;
         e_pend     = pend_ff;
         e_abs_left = abs_left_ff;
         e_pad      = pad_ff;
         e_rbc      = rbc_ff;
         e_dx       = dx_ff;
         e_done     = done_ff;
      end
   end

   // padded row size in bytes
   always_comb begin
      if (eight) begin
         row_bytes = 14'(((14'({1'b0, w_cl}) + 14'd3) >> 2) << 2);
      end else begin
         row_bytes = 14'(((14'({1'b0, w_cl}) + 14'd7) >> 3) << 2);
      end
   end

   assign rbc_inc = {1'b0, e_rbc} + 13'd1;
   assign abs_len = (e_abs_left >= 8'd2) ? 8'd2 : e_abs_left;

   always_comb begin
      phase_in    = e_phase;
      col_in      = e_col;
      row_in      = e_row;
      pend_in     = e_pend;
      abs_left_in = e_abs_left;
      pad_in      = e_pad;
      rbc_in      = e_rbc;
      dx_in       = e_dx;
      done_in     = e_done;
      emit_req    = 1'b0;
      emit_len    = 8'd0;
      emit_a      = 8'd0;
      emit_b      = 8'd0;
      end_res     = 1'b0;

      if (!e_done) begin
         if (!cfg.run_length_coded) begin
            emit_req = 1'b1;
            if (eight) begin
               emit_len = 8'd1;
               emit_a   = c;
               emit_b   = c;
            end else begin
               emit_len = 8'd2;
               emit_a   = {4'd0, c[7:4]};
               emit_b   = {4'd0, c[3:0]};
            end
            col_in = col_add(e_col, emit_len);
            if ({1'b0, rbc_inc} >= row_bytes) begin
               rbc_in = 12'd0;
               col_in = 16'd0;
               row_in = row_sub(e_row, 8'd1);
               if (row_in < 14'sd0) begin
                  done_in = 1'b1;
               end
            end else begin
               rbc_in = rbc_inc[11:0];
            end
         end else begin
            case (e_phase)
               PH_COUNT: begin
                  if (c != 8'd0) begin
                     pend_in  = c;
                     phase_in = PH_VALUE;
                  end else begin
                     phase_in = PH_ESCAPE;
                  end
               end
               PH_VALUE: begin
                  emit_req = 1'b1;
                  emit_len = e_pend;
                  if (eight) begin
                     emit_a = c;
                     emit_b = c;
                  end else begin
                     emit_a = {4'd0, c[7:4]};
                     emit_b = {4'd0, c[3:0]};
                  end
                  col_in   = col_add(e_col, e_pend);
                  pend_in  = 8'd0;
                  phase_in = PH_COUNT;
               end
               PH_ESCAPE: begin
                  phase_in = PH_COUNT;
                  if (c == 8'd0) begin
                     // end of line
                     col_in = 16'd0;
                     row_in = row_sub(e_row, 8'd1);
                  end else if (c == 8'd1) begin
                     done_in = 1'b1;
                     end_res = 1'b1;
                  end else if (c == 8'd2) begin
                     phase_in = PH_DELTA_X;
                  end else begin
                     abs_left_in = c;
                     if (eight) begin
                        pad_in = c[0];
                     end else begin
                        pad_in = (c[1:0] == 2'd1) || (c[1:0] == 2'd2);
                     end
                     phase_in = PH_ABS_DATA;
                  end
               end
               PH_DELTA_X: begin
                  dx_in    = c;
                  phase_in = PH_DELTA_Y;
               end
               PH_DELTA_Y: begin
                  col_in   = col_add(e_col, e_dx);
                  row_in   = row_sub(e_row, c);
                  dx_in    = 8'd0;
                  phase_in = PH_COUNT;
               end
               PH_ABS_DATA: begin
                  emit_req = 1'b1;
                  if (eight) begin
                     emit_len = 8'd1;
                     emit_a   = c;
                     emit_b   = c;
                  end else begin
                     emit_len = abs_len;
                     emit_a   = {4'd0, c[7:4]};
                     emit_b   = {4'd0, c[3:0]};
                  end
                  col_in      = col_add(e_col, emit_len);
                  abs_left_in = (e_abs_left > emit_len) ? e_abs_left - emit_len : 8'd0;
                  if (abs_left_in == 8'd0) begin
                     phase_in = e_pad ? PH_ABS_PAD : PH_COUNT;
                     pad_in   = 1'b0;
                  end
               end
               PH_ABS_PAD: begin
                  phase_in = PH_COUNT;
               end
               default: begin
                  phase_in = PH_COUNT;
               end
            endcase
         end
      end
   end

   // clip the run to the image
   assign in_image = !e_row[13] && (e_row[12:0] < h_cl) && (e_col < {3'd0, w_cl});
   assign room     = w_cl - e_col[12:0];
   assign clip_len = ({5'd0, emit_len} > room) ? room[7:0] : emit_len;
   assign emit_ok  = emit_req && in_image && (clip_len != 8'd0);

   always_comb begin
      res_item  = '0;
      res_valid = end_res || emit_ok;
      if (end_res) begin
         res_item.result_kind = KIND_IMAGE_END;
      end else begin
         res_item.result_kind  = KIND_RUN;
         res_item.run_x        = e_col[11:0];
         res_item.run_y        = e_row[11:0];
         res_item.run_length   = clip_len;
         res_item.first_index  = emit_a;
         res_item.second_index = (clip_len == 8'd1) ? emit_a : emit_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_COUNT;
         col_ff      <= 16'd0;
         row_ff      <= $signed({1'b0, clamp_dim(CFG_RESET.image_height)} - 14'd1);
         pend_ff     <= 8'd0;
         abs_left_ff <= 8'd0;
         pad_ff      <= 1'b0;
         rbc_ff      <= 12'd0;
         dx_ff       <= 8'd0;
         done_ff     <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         pend_ff     <= pend_in;
         abs_left_ff <= abs_left_in;
         pad_ff      <= pad_in;
         rbc_ff      <= rbc_in;
         dx_ff       <= dx_in;
         done_ff     <= done_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/bmp_rle_pixel_decoder_unit.sv */
// ----------------------------------------------------------------------------
// bmp_rle_pixel_decoder_unit
// Decodes 4/8-bit palette bitmap pixel data (raw rows or RLE4/RLE8) into
// clipped pixel runs, one stream byte per item.
// ----------------------------------------------------------------------------
//  channel   ports                                  role
//  req       req_valid, req_stall, req_item         stream bytes in
//  rsp       rsp_valid, rsp_stall, rsp_item         runs and image end out
//  csr       csr_valid, csr_ready, csr_index/wdata  register writes
//
//  One item per cycle while rsp_stall is low; a byte is registered on input,
//  decoded once the output register is free, and its result, if any, is put
//  in the output register. A stalled result holds it; one more item waits in
//  the input register, then req_stall rises. Reset is synchronous and restores
//  register defaults and the parse state. csr writes are always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_rle_pixel_decoder_unit (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_stall,
   input  bmprle_pkg::req_item_type                req_item,
   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output bmprle_pkg::rsp_item_type                rsp_item,
   input  wire                                     csr_valid,
   output logic                                    csr_ready,
   input  wire [bmprle_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire [12:0]                              csr_wdata
);
   import bmprle_pkg::*;

   cfg_type      cfg_ff;
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;

   logic         advance;
   logic         req_take;
   logic         res_valid;
   rsp_item_type res_item;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   bmprle_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .step      (advance),
      .item      (in_item_ff),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = res_valid;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance && res_valid) begin
         out_item_ff <= res_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:      cfg_ff.image_width      <= csr_wdata;
            CSR_IMAGE_HEIGHT:     cfg_ff.image_height     <= csr_wdata;
            CSR_PIXEL_DEPTH:      cfg_ff.pixel_depth      <= csr_wdata[0];
            CSR_RUN_LENGTH_CODED: cfg_ff.run_length_coded <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the bitmap pixel-data decoder with stream bytes (directed escapes,
// random raw and RLE images, noise, a column saturation row) under random
// register settings, predicts every run and image end, and checks the
// result channel item by item with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
   import bmprle_pkg::*;

   localparam int unsigned IDLE_LIMIT   = 1000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned RANDOM_ITEMS = 270;

   // rle escape codes (second byte after a zero count)
   localparam logic [7:0] RLE_ESCAPE        = 8'h00;
   localparam logic [7:0] ESC_END_OF_LINE   = 8'h00;
   localparam logic [7:0] ESC_END_OF_BITMAP = 8'h01;
   localparam logic [7:0] ESC_DELTA         = 8'h02;

   typedef enum logic [2:0] {
      PARSE_COUNT, PARSE_VALUE, PARSE_ESCAPE, PARSE_DELTA_X,
      PARSE_DELTA_Y, PARSE_ABS_DATA, PARSE_ABS_PAD
   } parse_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_item_type           req_item  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_item_type           rsp_item;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [12:0]            csr_wdata = '0;

   bmp_rle_pixel_decoder_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // decoder prediction
   // ------------------------------------------------------------------------
   cfg_type         cfg_now;
   parse_phase_type parse_at;
   int unsigned     col_at;
   int              row_at;
   logic [7:0]      count_held;
   logic [7:0]      abs_left;
   logic [7:0]      dx_held;
   bit              pad_due;
   bit              image_over;
   int unsigned     row_fill;

   rsp_item_type runs_due[$];
   int unsigned  fault_count = 0;

   function automatic int unsigned dim_limit(input logic [12:0] v);
      if (v == 13'd0) begin
         return 1;
      end
      if (v > 13'(MAX_DIMENSION)) begin
         return MAX_DIMENSION;
      end
      return int'(v);
   endfunction

   function automatic void restart_image();
      parse_at   = PARSE_COUNT;
      col_at     = 0;
      row_at     = int'(dim_limit(cfg_now.image_height)) - 1;
      count_held = '0;
      abs_left   = '0;
      pad_due    = 1'b0;
      row_fill   = 0;
      dx_held    = '0;
      image_over = 1'b0;
   endfunction

   function automatic void advance_col(input int unsigned n);
      col_at = col_at + n;
      if (col_at > 65535) begin
         col_at = 65535;
      end
   endfunction

   function automatic void drop_rows(input int unsigned n);
      row_at = row_at - int'(n);
      if (row_at < -1) begin
         row_at = -1;
      end
   endfunction

   // run clipped to the image; nothing when wholly outside
   function automatic void note_run(input int unsigned len, input logic [7:0] a,
                                    input logic [7:0] b);
      int unsigned  w;
      int unsigned  h;
      rsp_item_type r;
      w = dim_limit(cfg_now.image_width);
      h = dim_limit(cfg_now.image_height);
      if (row_at < 0 || row_at >= int'(h) || col_at >= w) begin
         return;
      end
      if (len > w - col_at) begin
         len = w - col_at;
      end
      if (len == 0) begin
         return;
      end
      if (len == 1) begin
         b = a;
      end
      r.result_kind  = KIND_RUN;
      r.run_x        = col_at[11:0];
      r.run_y        = row_at[11:0];
      r.run_length   = len[7:0];
      r.first_index  = a;
      r.second_index = b;
      runs_due.push_back(r);
   endfunction

   function automatic void raw_byte(input logic [7:0] c);
      int unsigned w;
      int unsigned row_len;
      w = dim_limit(cfg_now.image_width);
      if (cfg_now.pixel_depth) begin
         row_len = ((w + 3) / 4) * 4;
         note_run(1, c, c);
         advance_col(1);
      end else begin
         row_len = ((w + 7) / 8) * 4;
         note_run(2, {4'h0, c[7:4]}, {4'h0, c[3:0]});
         advance_col(2);
      end
      row_fill++;
      if (row_fill >= row_len) begin
         row_fill = 0;
         col_at   = 0;
         drop_rows(1);
         if (row_at < 0) begin
            image_over = 1'b1;
         end
      end
   endfunction

   function automatic void rle_byte(input logic [7:0] c);
      bit           eight;
      int unsigned  len;
      rsp_item_type r;
      eight = cfg_now.pixel_depth;
      case (parse_at)
         PARSE_COUNT: begin
            if (c != RLE_ESCAPE) begin
               count_held = c;
               parse_at   = PARSE_VALUE;
            end else begin
               parse_at = PARSE_ESCAPE;
            end
         end
         PARSE_VALUE: begin
            if (eight) begin
               note_run(count_held, c, c);
            end else begin
               note_run(count_held, {4'h0, c[7:4]}, {4'h0, c[3:0]});
            end
            advance_col(count_held);
            count_held = '0;
            parse_at   = PARSE_COUNT;
         end
         PARSE_ESCAPE: begin
            parse_at = PARSE_COUNT;
            if (c == ESC_END_OF_LINE) begin
               col_at = 0;
               drop_rows(1);
            end else if (c == ESC_END_OF_BITMAP) begin
               image_over    = 1'b1;
               r             = '0;
               r.result_kind = KIND_IMAGE_END;
               runs_due.push_back(r);
            end else if (c == ESC_DELTA) begin
               parse_at = PARSE_DELTA_X;
            end else begin
               abs_left = c;
               pad_due  = eight ? c[0] : (c[1:0] == 2'd1 || c[1:0] == 2'd2);
               parse_at = PARSE_ABS_DATA;
            end
         end
         PARSE_DELTA_X: begin
            dx_held  = c;
            parse_at = PARSE_DELTA_Y;
         end
         PARSE_DELTA_Y: begin
            advance_col(dx_held);
            drop_rows(c);
            dx_held  = '0;
            parse_at = PARSE_COUNT;
         end
         PARSE_ABS_DATA: begin
            if (eight) begin
               len = 1;
               note_run(1, c, c);
            end else begin
               len = (abs_left >= 8'd2) ? 2 : abs_left;
               note_run(len, {4'h0, c[7:4]}, {4'h0, c[3:0]});
            end
            advance_col(len);
            abs_left = (abs_left > len) ? abs_left - len[7:0] : 8'd0;
            if (abs_left == 8'd0) begin
               parse_at = pad_due ? PARSE_ABS_PAD : PARSE_COUNT;
               pad_due  = 1'b0;
            end
         end
         default: begin
            parse_at = PARSE_COUNT;
         end
      endcase
   endfunction

   function automatic void decode_byte(input req_item_type it);
      if (it.image_start) begin
         restart_image();
      end
      if (image_over) begin
         return;
      end
      if (cfg_now.run_length_coded) begin
         rle_byte(it.data_byte);
      end else begin
         raw_byte(it.data_byte);
      end
   endfunction

   // ------------------------------------------------------------------------
   // byte driver
   // ------------------------------------------------------------------------
   req_item_type pending_bytes[$];
   int unsigned  send_gap    = 0;
   bit           sender_calm = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_item);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (pending_bytes.size() != 0) begin
               req_item  <= pending_bytes.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 39) == 0) begin
                  sender_calm = !sender_calm;
               end
               send_gap <= sender_calm ? 0 : $urandom_range(0, 4);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // result monitor
   // ------------------------------------------------------------------------
   int unsigned stall_left    = 0;
   bit          receiver_calm = 1'b0;

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      int unsigned  next_stall;
      rsp_item_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         next_stall = stall_left;
         if (rsp_valid && !rsp_stall) begin
            if (runs_due.size() == 0) begin
               $error("result with nothing expected: kind %0d x %0d y %0d len %0d",
                      rsp_item.result_kind, rsp_item.run_x, rsp_item.run_y,
                      rsp_item.run_length);
               fault_count++;
            end else begin
               want = runs_due.pop_front();
               compare_field("result_kind", want.result_kind, rsp_item.result_kind);
               compare_field("run_x", want.run_x, rsp_item.run_x);
               compare_field("run_y", want.run_y, rsp_item.run_y);
               compare_field("run_length", want.run_length, rsp_item.run_length);
               compare_field("first_index", want.first_index, rsp_item.first_index);
               compare_field("second_index", want.second_index, rsp_item.second_index);
            end
            if ($urandom_range(0, 39) == 0) begin
               receiver_calm = !receiver_calm;
            end
            next_stall = receiver_calm ? 0 : $urandom_range(0, 4);
         end
         if (next_stall != 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= next_stall - 1;
         end else begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog
   // ------------------------------------------------------------------------
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   bit          start_next   = 1'b0;
   bit          allow_stray  = 1'b0;
   int unsigned stim_count   = 0;

   task automatic push_byte(input int unsigned value);
      req_item_type it;
      it.data_byte   = value[7:0];
      it.image_start = start_next || (allow_stray && $urandom_range(0, 199) == 0);
      start_next     = 1'b0;
      pending_bytes.push_back(it);
      stim_count++;
   endtask

   // bytes after the image data; the block ignores them once the image is over
   task automatic push_tail();
      req_item_type it;
      repeat ($urandom_range(0, 2)) begin
         it.data_byte   = 8'($urandom);
         it.image_start = 1'b0;
         pending_bytes.push_back(it);
      end
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_bytes.size() != 0 || req_valid || runs_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [12:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:      cfg_now.image_width      = value;
         CSR_IMAGE_HEIGHT:     cfg_now.image_height     = value;
         CSR_PIXEL_DEPTH:      cfg_now.pixel_depth      = value[0];
         CSR_RUN_LENGTH_CODED: cfg_now.run_length_coded = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [12:0] w, input logic [12:0] h,
                             input bit deep, input bit coded);
      wait_drained();
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_PIXEL_DEPTH, 13'(deep));
      write_reg(CSR_RUN_LENGTH_CODED, 13'(coded));
   endtask

   function automatic logic [12:0] pick_dim(input int unsigned typical);
      case ($urandom_range(0, 31))
         0:       return 13'd0;
         1:       return 13'h1fff;
         2:       return 13'd4096;
         3:       return 13'd4097;
         4:       return 13'($urandom);
         5:       return 13'd1;
         default: return 13'($urandom_range(1, typical));
      endcase
   endfunction

   task automatic add_raw_image(input bit deep, input int unsigned w, input int unsigned h);
      int unsigned total;
      total = (deep ? ((w + 3) / 4) * 4 : ((w + 7) / 8) * 4) * h;
      // large images are only fed in part
      if (total > 120) begin
         total = $urandom_range(20, 120);
      end
      repeat (total) push_byte($urandom_range(0, 255));
      push_tail();
   endtask

   task automatic add_rle_image(input bit deep, input int unsigned w);
      int unsigned pick;
      int unsigned n;
      int unsigned data_bytes;
      repeat ($urandom_range(2, 16)) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                             : $urandom_range(1, (w + 2 > 255) ? 255 : w + 2);
            push_byte(n);
            push_byte($urandom_range(0, 255));
         end else if (pick < 60) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
            push_byte(RLE_ESCAPE);
            push_byte(n);
            data_bytes = deep ? n : (n + 1) / 2;
            repeat (data_bytes) push_byte($urandom_range(0, 255));
            // word padding
            if (data_bytes % 2 == 1) begin
               push_byte($urandom_range(0, 255));
            end
         end else if (pick < 78) begin
            push_byte(RLE_ESCAPE);
            push_byte(ESC_END_OF_LINE);
         end else if (pick < 92) begin
            push_byte(RLE_ESCAPE);
            push_byte(ESC_DELTA);
            push_byte(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 4));
            push_byte(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 2));
         end else begin
            push_byte($urandom_range(0, 255));
         end
      end
      // most streams close properly, some are cut short
      if ($urandom_range(0, 9) != 0) begin
         push_byte(RLE_ESCAPE);
         push_byte(ESC_END_OF_BITMAP);
         push_tail();
      end
   endtask

   initial begin
      logic [12:0] w_reg;
      logic [12:0] h_reg;
      bit          deep;
      bit          coded;
      cfg_now = CFG_RESET;
      restart_image();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // raw 8-bit single pixel image at the reset settings, then a byte after the end
      start_next = 1'b1;
      push_byte(8'hff);
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(8'h7e);

      // rle4 escapes: encoded run, absolute, end of line, delta, single pixel, end
      set_config(13'd3, 13'd2, 1'b0, 1'b1);
      start_next = 1'b1;
      push_byte(8'h03);
      push_byte(8'ha5);
      push_byte(RLE_ESCAPE);
      push_byte(8'h03);
      push_byte(8'h12);
      push_byte(8'h30);
      push_byte(RLE_ESCAPE);
      push_byte(ESC_END_OF_LINE);
      push_byte(RLE_ESCAPE);
      push_byte(ESC_DELTA);
      push_byte(8'h01);
      push_byte(8'h00);
      push_byte(8'h01);
      push_byte(8'hf0);
      push_byte(RLE_ESCAPE);
      push_byte(ESC_END_OF_BITMAP);
      push_byte(8'h00);

      allow_stray = 1'b1;
      stim_count  = 0;
      while (stim_count < RANDOM_ITEMS) begin
         w_reg = pick_dim(24);
         h_reg = pick_dim(6);
         deep  = $urandom_range(0, 1);
         coded = $urandom_range(0, 1);
         set_config(w_reg, h_reg, deep, coded);
         // sometimes keep the old parse state across the new settings
         start_next = ($urandom_range(0, 7) != 0);
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(6, 30)) push_byte($urandom_range(0, 255));
         end else if (coded) begin
            add_rle_image(deep, dim_limit(w_reg));
         end else begin
            add_raw_image(deep, dim_limit(w_reg), dim_limit(h_reg));
         end
      end
      allow_stray = 1'b0;

      // one long rle8 row pushes the column past its saturation point
      set_config(13'd4096, 13'd3, 1'b1, 1'b1);
      start_next = 1'b1;
      repeat (259) begin
         push_byte(8'hff);
         push_byte($urandom_range(0, 255));
      end
      push_byte(8'h05);
      push_byte(8'h33);
      push_byte(RLE_ESCAPE);
      push_byte(ESC_END_OF_LINE);
      push_byte(8'h04);
      push_byte(8'h44);
      // drop below the bottom row, runs there stay hidden
      push_byte(RLE_ESCAPE);
      push_byte(ESC_DELTA);
      push_byte(8'h00);
      push_byte(8'hff);
      push_byte(8'h02);
      push_byte(8'h55);
      push_byte(RLE_ESCAPE);
      push_byte(ESC_END_OF_LINE);
      push_byte(8'h01);
      push_byte(8'h66);
      push_byte(RLE_ESCAPE);
      push_byte(ESC_END_OF_BITMAP);

      wait_drained();
      if (fault_count == 0 && runs_due.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/bmprle_pkg.sv
hdl/bmprle_decode.sv
hdl/bmp_rle_pixel_decoder_unit.sv
verif/testbench.sv
